>>> hw/rtl/ptq_pkg.sv
// Shared types and constants for the periodic timer queue.
package ptq_pkg;

    localparam int MAX_TIMERS_DEF = 16;

    localparam logic [31:0] IDLE_WAIT_RESET = 32'(60 * 60 * 1000);

    localparam logic [1:0] ACT_SET   = 2'd0;
    localparam logic [1:0] ACT_KILL  = 2'd1;
    localparam logic [1:0] ACT_POLL  = 2'd2;
    localparam logic [1:0] ACT_QUERY = 2'd3;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] period;
        logic [63:0] deadline;
    } entry_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        fired;
        logic [31:0] fired_id;
        logic [63:0] wait_time;
        logic        table_empty;
    } res_t;

endpackage

>>> hw/rtl/ptq_slot_mem.sv
// Slot storage: id, period and deadline per timer, one write and one registered read port.
module ptq_slot_mem
    import ptq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t slot_mem [MAX_TIMERS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/ptq_ctrl.sv
// Sequencer: scans the slots through one shared compare unit and applies each command.
module ptq_ctrl
    import ptq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF,
    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       action,
    input  logic [31:0]      timer_id,
    input  logic [31:0]      interval,
    input  logic [63:0]      now,
    input  logic [31:0]      idle_wait,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res,
    output logic             mem_wr_en,
    output logic [IDX_W-1:0] mem_wr_addr,
    output entry_t           mem_wr_data,
    output logic [IDX_W-1:0] mem_rd_addr,
    input  entry_t           mem_rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_FIN,
        S_OUT
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TIMERS - 1);

    state_t                state_reg,       state_next;
    logic [1:0]            cmd_action_reg,  cmd_action_next;
    logic [31:0]           cmd_id_reg,      cmd_id_next;
    logic [31:0]           cmd_ival_reg,    cmd_ival_next;
    logic [63:0]           cmd_now_reg,     cmd_now_next;
    logic [IDX_W-1:0]      scan_idx_reg,    scan_idx_next;
    logic                  eval_vld_reg,    eval_vld_next;
    logic [IDX_W-1:0]      eval_idx_reg,    eval_idx_next;
    logic [MAX_TIMERS-1:0] valid_reg,       valid_next;
    logic                  match_found_reg, match_found_next;
    logic [IDX_W-1:0]      match_idx_reg,   match_idx_next;
    logic                  free_found_reg,  free_found_next;
    logic [IDX_W-1:0]      free_idx_reg,    free_idx_next;
    logic                  best_found_reg,  best_found_next;
    logic [IDX_W-1:0]      best_idx_reg,    best_idx_next;
    logic [63:0]           best_dl_reg,     best_dl_next;
    logic [31:0]           best_id_reg,     best_id_next;
    logic [31:0]           best_per_reg,    best_per_next;
    res_t                  res_reg,         res_next;

    logic eval_slot_valid;
    logic earlier;

    assign eval_slot_valid = valid_reg[eval_idx_reg];
    assign earlier = !best_found_reg
                     || (mem_rd_data.deadline < best_dl_reg)
                     || ((mem_rd_data.deadline == best_dl_reg)
                         && (mem_rd_data.id < best_id_reg));

    assign in_stall    = (state_reg != S_IDLE);
    assign res_valid   = (state_reg == S_OUT);
    assign res         = res_reg;
    assign mem_rd_addr = scan_idx_reg;

    always_comb
    begin
        state_next       = state_reg;
        cmd_action_next  = cmd_action_reg;
        cmd_id_next      = cmd_id_reg;
        cmd_ival_next    = cmd_ival_reg;
        cmd_now_next     = cmd_now_reg;
        scan_idx_next    = scan_idx_reg;
        eval_vld_next    = 1'b0;
        eval_idx_next    = scan_idx_reg;
        valid_next       = valid_reg;
        match_found_next = match_found_reg;
        match_idx_next   = match_idx_reg;
        free_found_next  = free_found_reg;
        free_idx_next    = free_idx_reg;
        best_found_next  = best_found_reg;
        best_idx_next    = best_idx_reg;
        best_dl_next     = best_dl_reg;
        best_id_next     = best_id_reg;
        best_per_next    = best_per_reg;
        res_next         = res_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = best_idx_reg;
        mem_wr_data      = '{id: best_id_reg, period: best_per_reg,
                             deadline: best_dl_reg + {32'd0, best_per_reg}};

        // fold the slot read last cycle into the running results
        if (eval_vld_reg)
        begin
            if (eval_slot_valid && (mem_rd_data.id == cmd_id_reg) && !match_found_reg)
            begin
                match_found_next = 1'b1;
                match_idx_next   = eval_idx_reg;
            end
            if (!eval_slot_valid && !free_found_reg)
            begin
                free_found_next = 1'b1;
                free_idx_next   = eval_idx_reg;
            end
            if (eval_slot_valid && earlier)
            begin
                best_found_next = 1'b1;
                best_idx_next   = eval_idx_reg;
                best_dl_next    = mem_rd_data.deadline;
                best_id_next    = mem_rd_data.id;
                best_per_next   = mem_rd_data.period;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_action_next  = action;
                    cmd_id_next      = timer_id;
                    cmd_ival_next    = interval;
                    cmd_now_next     = now;
                    scan_idx_next    = '0;
                    match_found_next = 1'b0;
                    free_found_next  = 1'b0;
                    best_found_next  = 1'b0;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                eval_vld_next = 1'b1;
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_TAIL;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_TAIL:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                res_next.status    = ST_DONE;
                res_next.fired     = 1'b0;
                res_next.fired_id  = '0;
                res_next.wait_time = '0;
                case (cmd_action_reg)
                    ACT_SET:
                    begin
                        if (match_found_reg || free_found_reg)
                        begin
                            mem_wr_en   = 1'b1;
                            mem_wr_addr = match_found_reg ? match_idx_reg : free_idx_reg;
                            mem_wr_data = '{id: cmd_id_reg, period: cmd_ival_reg,
                                            deadline: cmd_now_reg + {32'd0, cmd_ival_reg}};
                            valid_next[mem_wr_addr] = 1'b1;
                        end
                        else
                        begin
                            res_next.status = ST_FULL;
                        end
                    end
                    ACT_KILL:
                    begin
                        if (match_found_reg)
                        begin
                            valid_next[match_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                    end
                    ACT_POLL:
                    begin
                        if (best_found_reg && (cmd_now_reg >= best_dl_reg))
                        begin
                            mem_wr_en         = 1'b1;
                            res_next.fired    = 1'b1;
                            res_next.fired_id = best_id_reg;
                        end
                    end
                    default:
                    begin
                        if (!best_found_reg)
                        begin
                            res_next.wait_time = {32'd0, idle_wait};
                        end
                        else if (cmd_now_reg <= best_dl_reg)
                        begin
                            res_next.wait_time = best_dl_reg - cmd_now_reg;
                        end
                    end
                endcase
                res_next.table_empty = ~|valid_next;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cmd_action_reg  <= ACT_SET;
            cmd_id_reg      <= '0;
            cmd_ival_reg    <= '0;
            cmd_now_reg     <= '0;
            scan_idx_reg    <= '0;
            eval_vld_reg    <= 1'b0;
            eval_idx_reg    <= '0;
            valid_reg       <= '0;
            match_found_reg <= 1'b0;
            match_idx_reg   <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            best_found_reg  <= 1'b0;
            best_idx_reg    <= '0;
            best_dl_reg     <= '0;
            best_id_reg     <= '0;
            best_per_reg    <= '0;
            res_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            cmd_action_reg  <= cmd_action_next;
            cmd_id_reg      <= cmd_id_next;
            cmd_ival_reg    <= cmd_ival_next;
            cmd_now_reg     <= cmd_now_next;
            scan_idx_reg    <= scan_idx_next;
            eval_vld_reg    <= eval_vld_next;
            eval_idx_reg    <= eval_idx_next;
            valid_reg       <= valid_next;
            match_found_reg <= match_found_next;
            match_idx_reg   <= match_idx_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
            best_found_reg  <= best_found_next;
            best_idx_reg    <= best_idx_next;
            best_dl_reg     <= best_dl_next;
            best_id_reg     <= best_id_next;
            best_per_reg    <= best_per_next;
            res_reg         <= res_next;
        end
    end

endmodule

>>> hw/rtl/periodic_timer_queue_unit.sv
// Periodic timer queue: config register, slot storage, sequencer and output register.
// Transactions do not overlap: in_stall holds off the next one until the one-slot-per-cycle
//   scan through the single read port of the slot memory and the result hand-off are done.
// Reset: all slots inactive, idle_wait back to 3600000, output register empty.
// A finished result waits in the output register while the next transaction is taken.
module periodic_timer_queue_unit
    import ptq_pkg::*;
#(
    parameter int MAX_TIMERS = MAX_TIMERS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [31:0] timer_id,
    input  logic [31:0] interval,
    input  logic [63:0] now,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        fired,
    output logic [31:0] fired_id,
    output logic [63:0] wait_time,
    output logic        table_empty
);

    localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

    logic [31:0]      idle_wait_reg;
    logic             out_valid_reg;
    res_t             out_res_reg;
    logic             res_valid;
    logic             res_ready;
    res_t             res;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    entry_t           mem_wr_data;
    logic [IDX_W-1:0] mem_rd_addr;
    entry_t           mem_rd_data;

    assign res_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_wait_reg <= IDLE_WAIT_RESET;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                idle_wait_reg <= cfg_wr_data;
            end
            if (res_valid && res_ready)
            begin
                out_valid_reg <= 1'b1;
                out_res_reg   <= res;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    ptq_slot_mem #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    ptq_ctrl #(
        .MAX_TIMERS (MAX_TIMERS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .timer_id    (timer_id),
        .interval    (interval),
        .now         (now),
        .idle_wait   (idle_wait_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    assign out_valid   = out_valid_reg;
    assign status      = out_res_reg.status;
    assign fired       = out_res_reg.fired;
    assign fired_id    = out_res_reg.fired_id;
    assign wait_time   = out_res_reg.wait_time;
    assign table_empty = out_res_reg.table_empty;

endmodule

>>> dv/tb.sv
// Self-checking testbench for periodic_timer_queue_unit with a scoreboard that mirrors the timer table.
`timescale 1ns / 100ps

module tb;
    import ptq_pkg::*;

    localparam int ID_POOL       = 20;
    localparam int PHASE_ITEMS   = 375;
    localparam int SETTLE_CYCLES = 2 * (MAX_TIMERS_DEF + 4);

    class timer_table_tracker;
        bit          live [MAX_TIMERS_DEF];
        logic [31:0] ids [MAX_TIMERS_DEF];
        logic [31:0] periods [MAX_TIMERS_DEF];
        logic [63:0] deadlines [MAX_TIMERS_DEF];
        logic [31:0] idle_ms;
        res_t        awaited [$];
        int          errors;

        function new();
            foreach (live[i]) live[i] = 1'b0;
            idle_ms = IDLE_WAIT_RESET;
            errors  = 0;
        endfunction

        function int slot_of(logic [31:0] id);
            foreach (live[i])
                if (live[i] && ids[i] == id) return i;
            return -1;
        endfunction

        function int earliest_slot();
            int best;
            best = -1;
            foreach (live[i])
            begin
                if (!live[i]) continue;
                if (best < 0 || deadlines[i] < deadlines[best] ||
                    (deadlines[i] == deadlines[best] && ids[i] < ids[best]))
                    best = i;
            end
            return best;
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (live[i]) n += live[i];
            return n;
        endfunction

        function logic [31:0] pick_live_id();
            int idx [$];
            foreach (live[i]) if (live[i]) idx.push_back(i);
            return ids[idx[$urandom_range(idx.size() - 1)]];
        endfunction

        function void note_command(logic [1:0] act, logic [31:0] id, logic [31:0] ival,
                                   logic [63:0] t);
            res_t r;
            int   s;
            r = '0;
            case (act)
                ACT_SET:
                begin
                    s = slot_of(id);
                    if (s < 0)
                        foreach (live[i])
                            if (!live[i] && s < 0) s = i;
                    if (s < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        live[s]      = 1'b1;
                        ids[s]       = id;
                        periods[s]   = ival;
                        deadlines[s] = t + 64'(ival);
                    end
                end
                ACT_KILL:
                begin
                    s = slot_of(id);
                    if (s < 0) r.status = ST_NOT_FOUND;
                    else live[s] = 1'b0;
                end
                ACT_POLL:
                begin
                    s = earliest_slot();
                    if (s >= 0 && t >= deadlines[s])
                    begin
                        r.fired      = 1'b1;
                        r.fired_id   = ids[s];
                        deadlines[s] = deadlines[s] + 64'(periods[s]);
                    end
                end
                ACT_QUERY:
                begin
                    s = earliest_slot();
                    if (s < 0) r.wait_time = 64'(idle_ms);
                    else if (t <= deadlines[s]) r.wait_time = deadlines[s] - t;
                end
            endcase
            r.table_empty = (live_count() == 0);
            awaited.push_back(r);
        endfunction

        function void compare(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, got %0h", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (awaited.size() == 0)
            begin
                $error("result with no transaction pending");
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare("status", 64'(want.status), 64'(got.status));
            compare("fired", 64'(want.fired), 64'(got.fired));
            compare("fired_id", 64'(want.fired_id), 64'(got.fired_id));
            compare("wait_time", want.wait_time, got.wait_time);
            compare("table_empty", 64'(want.table_empty), 64'(got.table_empty));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [31:0] timer_id;
    logic [31:0] interval;
    logic [63:0] now;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic        fired;
    logic [31:0] fired_id;
    logic [63:0] wait_time;
    logic        table_empty;

    timer_table_tracker sb = new();
    logic [31:0]        id_pool [ID_POOL];
    logic [63:0]        clock_ms;
    bit                 sender_idles;
    bit                 receiver_stalls;

    periodic_timer_queue_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .timer_id    (timer_id),
        .interval    (interval),
        .now         (now),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .fired       (fired),
        .fired_id    (fired_id),
        .wait_time   (wait_time),
        .table_empty (table_empty)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
        out_stall <= receiver_stalls && ($urandom_range(99) < 34);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(res_t'({status, fired, fired_id, wait_time, table_empty}));

    task automatic send_command(input logic [1:0] act, input logic [31:0] id,
                                input logic [31:0] ival, input logic [63:0] t);
        int gap;
        gap = 0;
        if (sender_idles && $urandom_range(99) < 34) gap = $urandom_range(1, 24);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        timer_id <= id;
        interval <= ival;
        now      <= t;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_command(act, id, ival, t);
    endtask

    task automatic random_command();
        logic [1:0]  act;
        logic [31:0] id;
        logic [31:0] ival;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 32) act = ACT_SET;
        else if (pick < 55) act = ACT_KILL;
        else if (pick < 85) act = ACT_POLL;
        else act = ACT_QUERY;
        if (act == ACT_KILL && sb.live_count() != 0 && $urandom_range(99) < 70)
            id = sb.pick_live_id();
        else if ($urandom_range(99) < 8)
            id = $urandom;
        else
            id = id_pool[$urandom_range(ID_POOL - 1)];
        pick = $urandom_range(99);
        if (pick < 10) ival = '0;
        else if (pick < 70) ival = $urandom_range(40);
        else if (pick < 90) ival = $urandom_range(2000);
        else ival = $urandom;
        pick = $urandom_range(99);
        if (pick < 2) clock_ms = {$urandom, $urandom};
        else if (pick < 4) clock_ms = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(200));
        else clock_ms = clock_ms + 64'($urandom_range(12));
        send_command(act, id, ival, clock_ms);
    endtask

    task automatic drain_table();
        while (sb.live_count() != 0)
            send_command(ACT_KILL, sb.pick_live_id(), $urandom, clock_ms);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_idle_wait(input logic [31:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.idle_ms = value;
    endtask

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        action      <= ACT_SET;
        timer_id    <= '0;
        interval    <= '0;
        now         <= '0;
        sender_idles    = 1'b1;
        receiver_stalls = 1'b1;
        foreach (id_pool[k])
            id_pool[k] = (k < 10) ? 32'(k) : $urandom;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_command(ACT_QUERY, 32'd0, 32'd0, 64'd0);
        send_command(ACT_POLL, 32'd0, 32'd0, 64'd0);
        send_command(ACT_KILL, 32'd7, 32'd0, 64'd0);
        send_command(ACT_SET, 32'd0, 32'd0, 64'd100);
        send_command(ACT_POLL, 32'd0, 32'd0, 64'd100);
        send_command(ACT_SET, 32'd5, 32'd10, 64'd100);
        send_command(ACT_SET, 32'd0, 32'd10, 64'd100);
        send_command(ACT_QUERY, 32'd0, 32'd0, 64'd105);
        send_command(ACT_POLL, 32'd0, 32'd0, 64'd105);
        send_command(ACT_POLL, 32'd0, 32'd0, 64'd110);
        send_command(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0);
        send_command(ACT_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(ACT_POLL, 32'd0, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        for (int k = 0; k < 13; k++)
            send_command(ACT_SET, 32'd100 + 32'(k), 32'(k), 64'd200);
        send_command(ACT_SET, 32'd999, 32'd1, 64'd200);
        send_command(ACT_SET, 32'd5, 32'd3, 64'd200);
        send_command(ACT_KILL, 32'd5, 32'd0, 64'd200);
        clock_ms = 64'd300;
        drain_table();
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: write_idle_wait(32'h0);
                1: write_idle_wait(32'hFFFF_FFFF);
                default: write_idle_wait($urandom);
            endcase
            sender_idles    = (p != 2);
            receiver_stalls = (p != 2);
            send_command(ACT_QUERY, $urandom, $urandom, clock_ms);
            send_command(ACT_POLL, $urandom, $urandom, clock_ms);
            repeat (PHASE_ITEMS) random_command();
            drain_table();
            send_command(ACT_QUERY, $urandom, $urandom, {$urandom, $urandom});
            wait_drained();
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
